// ----- src/mpfb_pkg.sv -----
// Package for the page-layout monochrome framebuffer block.
// Holds display geometry, command codes and the controller/datapath structs.
// No dependencies.
package mpfb_pkg;

	localparam int DISPLAY_WIDTH = 128;
	localparam int DISPLAY_HEIGHT = 64;
	localparam int PAGE_COUNT = (DISPLAY_HEIGHT + 7) / 8;
	localparam int STORE_BYTES = DISPLAY_WIDTH * PAGE_COUNT;
	localparam int ADDR_W = $clog2(STORE_BYTES);

	typedef enum logic [2:0] {
		CMD_PIXEL_WRITE = 3'd0,
		CMD_PIXEL_READ  = 3'd1,
		CMD_FILL        = 3'd2,
		CMD_BITMAP      = 3'd3,
		CMD_CLEAR       = 3'd4,
		CMD_BYTE_READ   = 3'd5
	} cmd_t;

	typedef struct packed {
		logic load;
		logic rd_en;
		logic wr_en;
		logic step;
		logic clr_wr;
		logic res_load;
	} dp_cmd_t;

	typedef struct packed {
		logic active;
		logic last;
		logic clr_last;
	} dp_stat_t;

endpackage

// ----- src/mono_page_framebuffer_draw_top.sv -----
// Each item runs as read-modify-write passes over the single store port: one pass for pixel
// write, pixel read, byte read and unused codes, two for a bitmap byte (two store bytes, one
// each), one per covered store byte for a region fill (one when rejected or empty); a clear
// instead sweeps every store byte to zero. A new item is taken only once the controller is
// back in idle with the last result loaded; a result still waiting on out_ready holds the
// controller. After reset the store is swept to zero before the first item is taken.
module mono_page_framebuffer_draw_top (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [2:0] command,
	input  logic [7:0] x,
	input  logic [6:0] y,
	input  logic [7:0] width,
	input  logic [6:0] height,
	input  logic       pixel_value,
	input  logic       background,
	input  logic [7:0] bitmap_byte,
	input  logic [6:0] bitmap_column,
	input  logic [3:0] page,
	output logic       out_valid,
	input  logic       out_ready,
	output logic       read_pixel,
	output logic [7:0] read_byte,
	output logic       rejected
);
	import mpfb_pkg::*;

	dp_cmd_t  dp_cmd;
	dp_stat_t dp_stat;

	mpfb_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_command (command),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.dp_cmd     (dp_cmd),
		.dp_stat    (dp_stat)
	);

	mpfb_datapath u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.dp_cmd        (dp_cmd),
		.dp_stat       (dp_stat),
		.command       (command),
		.x             (x),
		.y             (y),
		.width         (width),
		.height        (height),
		.pixel_value   (pixel_value),
		.background    (background),
		.bitmap_byte   (bitmap_byte),
		.bitmap_column (bitmap_column),
		.page          (page),
		.read_pixel    (read_pixel),
		.read_byte     (read_byte),
		.rejected      (rejected)
	);

endmodule

// ----- src/mpfb_ctrl.sv -----
// Controller state machine for the framebuffer block.
// Sequences read-modify-write passes, clear sweeps and result transfers; uses mpfb_pkg.
module mpfb_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [2:0]         in_command,
	output logic               out_valid,
	input  logic               out_ready,
	output mpfb_pkg::dp_cmd_t  dp_cmd,
	input  mpfb_pkg::dp_stat_t dp_stat
);
	import mpfb_pkg::*;

	typedef enum logic [5:0] {
		ST_INIT  = 6'b000001,
		ST_IDLE  = 6'b000010,
		ST_READ  = 6'b000100,
		ST_WRITE = 6'b001000,
		ST_CLEAR = 6'b010000,
		ST_DONE  = 6'b100000
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   slot_free;

	assign slot_free = !out_valid_q || out_ready;
	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		dp_cmd  = '0;
		case (state_q)
			ST_INIT: begin
				dp_cmd.clr_wr = 1'b1;
				if (dp_stat.clr_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (in_valid) begin
					dp_cmd.load = 1'b1;
					state_d = (in_command == CMD_CLEAR) ? ST_CLEAR : ST_READ;
				end
			end
			ST_READ: begin
				dp_cmd.rd_en = 1'b1;
				state_d = ST_WRITE;
			end
			ST_WRITE: begin
				dp_cmd.wr_en = dp_stat.active;
				if (!dp_stat.last) begin
					dp_cmd.step = 1'b1;
					state_d = ST_READ;
				end else if (slot_free) begin
					dp_cmd.res_load = 1'b1;
					state_d = ST_IDLE;
				end else begin
					state_d = ST_DONE;
				end
			end
			ST_CLEAR: begin
				dp_cmd.clr_wr = 1'b1;
				if (dp_stat.clr_last) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (slot_free) begin
					dp_cmd.res_load = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_INIT;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_INIT;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (dp_cmd.res_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ----- src/mpfb_datapath.sv -----
// Datapath for the framebuffer block: command registers, cursor, masks,
// the frame store memory and the result register; uses mpfb_pkg.
module mpfb_datapath (
	input  logic               clk,
	input  logic               arst_n,
	input  mpfb_pkg::dp_cmd_t  dp_cmd,
	output mpfb_pkg::dp_stat_t dp_stat,
	input  logic [2:0]         command,
	input  logic [7:0]         x,
	input  logic [6:0]         y,
	input  logic [7:0]         width,
	input  logic [6:0]         height,
	input  logic               pixel_value,
	input  logic               background,
	input  logic [7:0]         bitmap_byte,
	input  logic [6:0]         bitmap_column,
	input  logic [3:0]         page,
	output logic               read_pixel,
	output logic [7:0]         read_byte,
	output logic               rejected
);
	import mpfb_pkg::*;

	logic [2:0]        cmd_q;
	logic [7:0]        x_q;
	logic [6:0]        y_q;
	logic [7:0]        w_q;
	logic [6:0]        h_q;
	logic              pv_q;
	logic              bg_q;
	logic [7:0]        bits_q;
	logic [6:0]        col_q;
	logic [3:0]        pg_q;
	logic [8:0]        cur_x_q;
	logic [4:0]        cur_pg_q;
	logic              pass_q;
	logic [ADDR_W-1:0] clr_addr_q;
	logic [7:0]        rdata_q;
	logic              read_pixel_q;
	logic [7:0]        read_byte_q;
	logic              rejected_q;

	logic [7:0]        mem [STORE_BYTES];

	logic [8:0]        bmp_x;
	logic [8:0]        bmp_base;
	logic [8:0]        x_end;
	logic [4:0]        pg_last;
	logic              rej;
	logic              empty;
	logic              pix_ok;
	logic              byte_ok;
	logic [15:0]       addr_full;
	logic [ADDR_W-1:0] cur_addr;
	logic [7:0]        wmask;
	logic [7:0]        wdata;
	logic [7:0]        merged;
	logic              fill_last;

	assign bmp_x    = 9'(x_q) + 9'(col_q);
	assign bmp_base = 9'(y_q) + {2'b00, pg_q, 3'b000};
	assign x_end    = 9'(x_q) + 9'(w_q) - 9'd1;
	assign pg_last  = 5'((8'(y_q) + 8'(h_q) - 8'd1) >> 3);
	assign rej      = (10'(x_q) + 10'(w_q) > 10'(DISPLAY_WIDTH))
		|| (9'(y_q) + 9'(h_q) > 9'(DISPLAY_HEIGHT));
	assign empty    = (w_q == 8'd0) || (h_q == 7'd0);
	assign pix_ok   = (9'(x_q) < 9'(DISPLAY_WIDTH)) && (8'(y_q) < 8'(DISPLAY_HEIGHT));
	assign byte_ok  = (9'(x_q) < 9'(DISPLAY_WIDTH)) && (5'(pg_q) < 5'(PAGE_COUNT));

	assign addr_full = 16'(cur_x_q) + 16'(cur_pg_q) * 16'(DISPLAY_WIDTH);
	assign cur_addr  = addr_full[ADDR_W-1:0];

	always_comb begin
		logic [8:0] row;
		logic [8:0] s9;
		logic [2:0] s;
		logic [7:0] src_row;
		wmask = '0;
		wdata = '0;
		for (int d = 0; d < 8; d++) begin
			row     = {1'b0, cur_pg_q, 3'b000} + 9'(d);
			s9      = row - bmp_base;
			s       = s9[2:0];
			src_row = {1'b0, pg_q, 3'b000} + 8'(s);
			case (cmd_q)
				CMD_PIXEL_WRITE: begin
					wmask[d] = pix_ok && (y_q[2:0] == 3'(d));
					wdata[d] = pv_q;
				end
				CMD_FILL: begin
					wmask[d] = !rej && !empty && (row >= 9'(y_q))
						&& (row < 9'(y_q) + 9'(h_q));
					wdata[d] = pv_q;
				end
				CMD_BITMAP: begin
					wmask[d] = (row >= bmp_base) && (s9 < 9'd8) && (src_row < 8'(h_q))
						&& (row < 9'(DISPLAY_HEIGHT)) && (bmp_x < 9'(DISPLAY_WIDTH))
						&& (bits_q[s] || bg_q);
					wdata[d] = bits_q[s];
				end
				default: begin
					wmask[d] = 1'b0;
					wdata[d] = 1'b0;
				end
			endcase
		end
	end

	assign merged    = (rdata_q & ~wmask) | (wdata & wmask);
	assign fill_last = rej || empty || ((cur_x_q == x_end) && (cur_pg_q == pg_last));

	always_comb begin
		dp_stat.active   = (wmask != 8'd0);
		dp_stat.clr_last = (clr_addr_q == ADDR_W'(STORE_BYTES - 1));
		case (cmd_q)
			CMD_FILL:   dp_stat.last = fill_last;
			CMD_BITMAP: dp_stat.last = pass_q;
			default:    dp_stat.last = 1'b1;
		endcase
	end

	always_ff @(posedge clk) begin
		if (dp_cmd.load) begin
			cmd_q  <= command;
			x_q    <= x;
			y_q    <= y;
			w_q    <= width;
			h_q    <= height;
			pv_q   <= pixel_value;
			bg_q   <= background;
			bits_q <= bitmap_byte;
			col_q  <= bitmap_column;
			pg_q   <= page;
			pass_q <= 1'b0;
			case (command)
				CMD_BITMAP: begin
					cur_x_q  <= 9'(x) + 9'(bitmap_column);
					cur_pg_q <= 5'((9'(y) + {2'b00, page, 3'b000}) >> 3);
				end
				CMD_BYTE_READ: begin
					cur_x_q  <= 9'(x);
					cur_pg_q <= 5'(page);
				end
				default: begin
					cur_x_q  <= 9'(x);
					cur_pg_q <= 5'(y >> 3);
				end
			endcase
		end else if (dp_cmd.step) begin
			if (cmd_q == CMD_FILL) begin
				if (cur_x_q == x_end) begin
					cur_x_q  <= 9'(x_q);
					cur_pg_q <= cur_pg_q + 5'd1;
				end else begin
					cur_x_q <= cur_x_q + 9'd1;
				end
			end else begin
				cur_pg_q <= cur_pg_q + 5'd1;
				pass_q   <= 1'b1;
			end
		end
		if (dp_cmd.res_load) begin
			read_pixel_q <= (cmd_q == CMD_PIXEL_READ) && pix_ok && rdata_q[y_q[2:0]];
			read_byte_q  <= ((cmd_q == CMD_BYTE_READ) && byte_ok) ? rdata_q : 8'd0;
			rejected_q   <= (cmd_q == CMD_FILL) && rej;
		end
	end

	always_ff @(posedge clk) begin
		if (dp_cmd.clr_wr) begin
			mem[clr_addr_q] <= 8'd0;
		end else if (dp_cmd.wr_en) begin
			mem[cur_addr] <= merged;
		end
		if (dp_cmd.rd_en) begin
			rdata_q <= mem[cur_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q <= '0;
		end else if (dp_cmd.clr_wr) begin
			clr_addr_q <= dp_stat.clr_last ? '0 : clr_addr_q + ADDR_W'(1);
		end
	end

	assign read_pixel = read_pixel_q;
	assign read_byte  = read_byte_q;
	assign rejected   = rejected_q;

endmodule

// ----- tb/sv/mono_page_framebuffer_draw_top_test.sv -----
// Testbench for mono_page_framebuffer_draw_top: drawing commands against a page-layout pixel model.
// Random valid/ready gaps are used on both channels. Results are checked in order.
// Depends on mpfb_pkg and the mono_page_framebuffer_draw_top RTL.
module mono_page_framebuffer_draw_top_test;
	timeunit 1ns;
	timeprecision 1ps;

	import mpfb_pkg::*;

	localparam logic [2:0] CMD_SPARE_6 = 3'd6;
	localparam logic [2:0] CMD_SPARE_7 = 3'd7;
	localparam int STALL_LIMIT = 12000;
	localparam int MAX_REPORTS = 10;
	localparam int SETTLE_CYCLES = 100;

	typedef struct {
		logic [2:0] command;
		logic [7:0] x;
		logic [6:0] y;
		logic [7:0] width;
		logic [6:0] height;
		logic       pixel_value;
		logic       background;
		logic [7:0] bitmap_byte;
		logic [6:0] bitmap_column;
		logic [3:0] page;
	} draw_item_t;

	typedef struct {
		logic       read_pixel;
		logic [7:0] read_byte;
		logic       rejected;
	} draw_result_t;

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_ready;
	logic [2:0] command;
	logic [7:0] x;
	logic [6:0] y;
	logic [7:0] width;
	logic [6:0] height;
	logic       pixel_value;
	logic       background;
	logic [7:0] bitmap_byte;
	logic [6:0] bitmap_column;
	logic [3:0] page;
	logic       out_valid;
	logic       out_ready;
	logic       read_pixel;
	logic [7:0] read_byte;
	logic       rejected;

	logic [7:0]   frame_model [STORE_BYTES];
	draw_result_t pending_results [$];
	int           mismatches = 0;
	int           items_sent = 0;
	int           results_seen = 0;
	int           quiet_cycles = 0;
	bit           idle_enable = 1'b1;

	mono_page_framebuffer_draw_top DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.command(command),
		.x(x),
		.y(y),
		.width(width),
		.height(height),
		.pixel_value(pixel_value),
		.background(background),
		.bitmap_byte(bitmap_byte),
		.bitmap_column(bitmap_column),
		.page(page),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.read_pixel(read_pixel),
		.read_byte(read_byte),
		.rejected(rejected)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic void plot(input int px, input int py, input bit v);
		int idx;
		if (px >= DISPLAY_WIDTH || py >= DISPLAY_HEIGHT) return;
		idx = px + (py / 8) * DISPLAY_WIDTH;
		frame_model[idx][py % 8] = v;
	endfunction

	function automatic logic probe(input int px, input int py);
		if (px >= DISPLAY_WIDTH || py >= DISPLAY_HEIGHT) return 1'b0;
		return frame_model[px + (py / 8) * DISPLAY_WIDTH][py % 8];
	endfunction

	function automatic draw_result_t predict_draw(input draw_item_t it);
		draw_result_t res;
		int px, py, w, h, pg, row;
		logic bit_v;
		res = '{1'b0, 8'd0, 1'b0};
		px = it.x;
		py = it.y;
		w = it.width;
		h = it.height;
		pg = it.page;
		case (it.command)
			CMD_PIXEL_WRITE: plot(px, py, it.pixel_value);
			CMD_PIXEL_READ: res.read_pixel = probe(px, py);
			CMD_FILL: begin
				if (px + w > DISPLAY_WIDTH || py + h > DISPLAY_HEIGHT) begin
					res.rejected = 1'b1;
				end else begin
					for (int r = 0; r < h; r++)
						for (int c = 0; c < w; c++)
							plot(px + c, py + r, it.pixel_value);
				end
			end
			CMD_BITMAP: begin
				for (int b = 0; b < 8; b++) begin
					row = pg * 8 + b;
					bit_v = it.bitmap_byte[b];
					if (row >= h) continue;
					if (bit_v || it.background)
						plot(px + int'(it.bitmap_column), py + row, bit_v);
				end
			end
			CMD_CLEAR: begin
				foreach (frame_model[i]) frame_model[i] = 8'h00;
			end
			CMD_BYTE_READ: begin
				if (px < DISPLAY_WIDTH && pg < PAGE_COUNT)
					res.read_byte = frame_model[px + pg * DISPLAY_WIDTH];
			end
			default: ;
		endcase
		return res;
	endfunction

	function automatic draw_item_t make_draw(input logic [2:0] cmd, input int px, input int py,
			input int w, input int h, input int pv, input int bg, input int bits,
			input int col, input int pg);
		draw_item_t it;
		it.command = cmd;
		it.x = 8'(px);
		it.y = 7'(py);
		it.width = 8'(w);
		it.height = 7'(h);
		it.pixel_value = 1'(pv);
		it.background = 1'(bg);
		it.bitmap_byte = 8'(bits);
		it.bitmap_column = 7'(col);
		it.page = 4'(pg);
		return it;
	endfunction

	task automatic send_draw(input draw_item_t it);
		int gap;
		gap = (idle_enable && $urandom_range(0, 3) == 0) ? $urandom_range(1, 7) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		command <= it.command;
		x <= it.x;
		y <= it.y;
		width <= it.width;
		height <= it.height;
		pixel_value <= it.pixel_value;
		background <= it.background;
		bitmap_byte <= it.bitmap_byte;
		bitmap_column <= it.bitmap_column;
		page <= it.page;
		do @(posedge clk); while (!in_ready);
		pending_results.push_back(predict_draw(it));
		items_sent++;
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending_results.size() != 0);
	endtask

	task automatic note_mismatch(input string what, input logic [7:0] want_v,
			input logic [7:0] got_v);
		mismatches++;
		if (mismatches <= MAX_REPORTS)
			$display("Result %0d, %s: expected %0h, actual %0h", results_seen, what, want_v,
				got_v);
	endtask

	// Result side: random stalls on out_ready, in-order checks and the stall watchdog.
	initial begin
		draw_result_t want;
		int stall_left;
		stall_left = 0;
		out_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (out_valid && out_ready) begin
				results_seen++;
				if (pending_results.size() == 0) begin
					note_mismatch("transfer with nothing pending, read_byte", 8'h00, read_byte);
				end else begin
					want = pending_results.pop_front();
					if (read_pixel !== want.read_pixel)
						note_mismatch("read_pixel", 8'(want.read_pixel), 8'(read_pixel));
					if (read_byte !== want.read_byte)
						note_mismatch("read_byte", want.read_byte, read_byte);
					if (rejected !== want.rejected)
						note_mismatch("rejected", 8'(want.rejected), 8'(rejected));
				end
			end
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (stall_left > 0) begin
				stall_left--;
				out_ready <= 1'b0;
			end else if (idle_enable && $urandom_range(0, 5) == 0) begin
				stall_left = $urandom_range(1, 7) - 1;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	initial begin
		wait (quiet_cycles >= STALL_LIMIT);
		$display("Mismatches found");
		$finish;
	end

	task automatic test_pixel_edges();
		send_draw(make_draw(CMD_PIXEL_WRITE, 0, 0, 0, 0, 1, 0, 0, 0, 0));
		send_draw(make_draw(CMD_PIXEL_WRITE, 127, 63, 0, 0, 1, 0, 0, 0, 0));
		send_draw(make_draw(CMD_PIXEL_WRITE, 128, 5, 0, 0, 1, 0, 0, 0, 0));
		send_draw(make_draw(CMD_PIXEL_WRITE, 255, 127, 0, 0, 1, 0, 0, 0, 0));
		send_draw(make_draw(CMD_PIXEL_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		send_draw(make_draw(CMD_PIXEL_READ, 127, 63, 0, 0, 0, 0, 0, 0, 0));
		send_draw(make_draw(CMD_PIXEL_READ, 255, 127, 0, 0, 0, 0, 0, 0, 0));
		send_draw(make_draw(CMD_PIXEL_READ, 3, 64, 0, 0, 0, 0, 0, 0, 0));
	endtask

	task automatic test_region_fill();
		send_draw(make_draw(CMD_FILL, 0, 0, 128, 64, 1, 0, 0, 0, 0));
		send_draw(make_draw(CMD_BYTE_READ, 127, 0, 0, 0, 0, 0, 0, 0, 7));
		send_draw(make_draw(CMD_FILL, 1, 0, 128, 8, 0, 0, 0, 0, 0));
		send_draw(make_draw(CMD_FILL, 0, 1, 8, 64, 0, 0, 0, 0, 0));
		send_draw(make_draw(CMD_FILL, 255, 127, 255, 127, 0, 0, 0, 0, 0));
		send_draw(make_draw(CMD_FILL, 0, 0, 0, 10, 0, 0, 0, 0, 0));
		send_draw(make_draw(CMD_FILL, 10, 5, 4, 0, 0, 0, 0, 0, 0));
		send_draw(make_draw(CMD_FILL, 8, 4, 3, 9, 0, 0, 0, 0, 0));
		send_draw(make_draw(CMD_BYTE_READ, 9, 0, 0, 0, 0, 0, 0, 0, 1));
	endtask

	task automatic test_clear_and_byte_read();
		send_draw(make_draw(CMD_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		send_draw(make_draw(CMD_BYTE_READ, 127, 0, 0, 0, 0, 0, 0, 0, 7));
		send_draw(make_draw(CMD_BYTE_READ, 128, 0, 0, 0, 0, 0, 0, 0, 0));
		send_draw(make_draw(CMD_BYTE_READ, 0, 0, 0, 0, 0, 0, 0, 0, 8));
		send_draw(make_draw(CMD_SPARE_6, 255, 127, 255, 127, 1, 1, 255, 127, 15));
		send_draw(make_draw(CMD_SPARE_7, 5, 5, 5, 5, 1, 1, 255, 3, 0));
	endtask

	task automatic test_bitmap_bytes();
		// Height cuts the byte after five rows; the second byte also writes zero pixels.
		send_draw(make_draw(CMD_BITMAP, 10, 3, 0, 5, 0, 0, 8'hA5, 2, 0));
		send_draw(make_draw(CMD_BYTE_READ, 12, 0, 0, 0, 0, 0, 0, 0, 0));
		send_draw(make_draw(CMD_BITMAP, 10, 3, 0, 5, 0, 1, 8'h5A, 2, 0));
		send_draw(make_draw(CMD_BYTE_READ, 12, 0, 0, 0, 0, 0, 0, 0, 0));
		send_draw(make_draw(CMD_BITMAP, 250, 120, 0, 127, 0, 1, 8'hFF, 127, 15));
		send_draw(make_draw(CMD_BITMAP, 120, 60, 0, 8, 0, 0, 8'hFF, 7, 0));
		send_draw(make_draw(CMD_BYTE_READ, 127, 0, 0, 0, 0, 0, 0, 0, 7));
	endtask

	// Mostly well-formed drawing sequences that are read back, with some noise mixed in.
	task automatic run_sequences(input int count, input bit allow_idle);
		int target, kind, n, fx, fy, fw, fh, cols, pages;
		int px [8];
		int py [8];
		bit bg;
		target = items_sent + count;
		while (items_sent < target) begin
			idle_enable = allow_idle && ($urandom_range(0, 3) != 0);
			kind = $urandom_range(0, 99);
			if (kind < 30) begin
				n = $urandom_range(2, 8);
				for (int i = 0; i < n; i++) begin
					px[i] = $urandom_range(0, 135);
					py[i] = $urandom_range(0, 70);
					send_draw(make_draw(CMD_PIXEL_WRITE, px[i], py[i], 0, 0,
						$urandom_range(0, 1), 0, 0, 0, 0));
				end
				for (int i = 0; i < n; i++)
					send_draw(make_draw(CMD_PIXEL_READ, px[i], py[i], 0, 0, 0, 0, 0, 0, 0));
			end else if (kind < 50) begin
				fx = $urandom_range(0, 127);
				fy = $urandom_range(0, 63);
				fw = $urandom_range(0, 16);
				fh = $urandom_range(0, 16);
				send_draw(make_draw(CMD_FILL, fx, fy, fw, fh, $urandom_range(0, 1), 0, 0, 0, 0));
				n = $urandom_range(1, 3);
				for (int i = 0; i < n; i++)
					send_draw(make_draw(CMD_BYTE_READ, fx + $urandom_range(0, fw), 0, 0, 0, 0,
						0, 0, 0, (fy + $urandom_range(0, fh)) / 8));
			end else if (kind < 70) begin
				fx = $urandom_range(0, 130);
				fy = $urandom_range(0, 70);
				fh = $urandom_range(1, 24);
				cols = $urandom_range(1, 6);
				pages = (fh + 7) / 8;
				bg = 1'($urandom_range(0, 1));
				for (int c = 0; c < cols; c++)
					for (int p = 0; p < pages; p++)
						send_draw(make_draw(CMD_BITMAP, fx, fy, 0, fh, 0, bg,
							$urandom_range(0, 255), c, p));
				n = $urandom_range(1, 3);
				for (int i = 0; i < n; i++)
					send_draw(make_draw(CMD_BYTE_READ, fx + $urandom_range(0, cols), 0, 0, 0,
						0, 0, 0, 0, $urandom_range(0, 8)));
			end else if (kind < 90) begin
				n = $urandom_range(1, 4);
				for (int i = 0; i < n; i++)
					send_draw(make_draw(3'($urandom_range(0, 7)), $urandom_range(0, 255),
						$urandom_range(0, 127), $urandom_range(0, 255),
						$urandom_range(0, 127), $urandom_range(0, 1), $urandom_range(0, 1),
						$urandom_range(0, 255), $urandom_range(0, 127),
						$urandom_range(0, 15)));
			end else if (kind < 93) begin
				fx = $urandom_range(0, 64);
				fy = $urandom_range(0, 32);
				send_draw(make_draw(CMD_FILL, fx, fy, $urandom_range(32, DISPLAY_WIDTH - fx),
					$urandom_range(16, DISPLAY_HEIGHT - fy), $urandom_range(0, 1), 0, 0, 0,
					0));
			end else begin
				n = $urandom_range(2, 6);
				for (int i = 0; i < n; i++)
					send_draw(make_draw(CMD_BYTE_READ, $urandom_range(0, 135), 0, 0, 0, 0, 0,
						0, 0, $urandom_range(0, 9)));
			end
		end
	endtask

	task automatic test_random_drawing();
		run_sequences(850, 1'b1);
		drain_results();
		run_sequences(920, 1'b1);
	endtask

	task automatic test_full_speed();
		run_sequences(150, 1'b0);
	endtask

	initial begin
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		command <= CMD_PIXEL_WRITE;
		x <= '0;
		y <= '0;
		width <= '0;
		height <= '0;
		pixel_value <= 1'b0;
		background <= 1'b0;
		bitmap_byte <= '0;
		bitmap_column <= '0;
		page <= '0;
		foreach (frame_model[i]) frame_model[i] = 8'h00;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		test_pixel_edges();
		test_region_fill();
		test_clear_and_byte_read();
		test_bitmap_bytes();
		drain_results();
		test_random_drawing();
		test_full_speed();
		drain_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0 && pending_results.size() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
